// ----- rtl/json_text_field_unescaper_macros.svh -----
// assertion macros used by the checker file
`ifndef JSON_TEXT_FIELD_UNESCAPER_MACROS_SVH
`define JSON_TEXT_FIELD_UNESCAPER_MACROS_SVH

// property checked at every clock edge outside reset
`define JTFU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define JTFU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/jtfu_pkg.sv -----
// ----------------------------------------------------------------------------
// jtfu_pkg
// Shared types and constants of the JSON text field unescaper.
// ----------------------------------------------------------------------------
package jtfu_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned DefQueueDepth = 4;

  // result kinds
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_DONE   = 3'd1;
  localparam logic [2:0] KIND_NOKEY  = 3'd2;
  localparam logic [2:0] KIND_BADHEX = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] out_kind;
    logic       out_last;
  } out_word_t;

  // work for the back end from one input word, emitted in field order:
  // code point as utf-8, then a single byte, then a status
  typedef struct packed {
    logic        cp_valid;
    logic [20:0] cp;
    logic        data_valid;
    logic [7:0]  data;
    logic        stat_valid;
    logic [2:0]  stat_kind;
  } cmd_t;

endpackage

// ----- rtl/jtfu_queue.sv -----
// ----------------------------------------------------------------------------
// jtfu_queue
// Small register queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module jtfu_queue #(
  parameter int unsigned Depth = jtfu_pkg::DefQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jtfu_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output jtfu_pkg::cmd_t  data_o
);
  import jtfu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/jtfu_front.sv -----
// ----------------------------------------------------------------------------
// jtfu_front
// Key search and string parser: each input word gives at most one command.
// ----------------------------------------------------------------------------
module jtfu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jtfu_pkg::in_word_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output jtfu_pkg::cmd_t     cmd_o
);
  import jtfu_pkg::*;

  typedef enum logic [3:0] {
    PhKey1, PhKey2, PhOpen, PhStr, PhEsc, PhHex1,
    PhPairB, PhPairU, PhHex2, PhDone, PhFail
  } phase_e;

  localparam logic [7:0] Quote     = 8'h22;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] LetterU   = 8'h75;
  localparam logic [3:0] Key1Len   = 4'd14;
  localparam logic [3:0] Key2Len   = 4'd6;

  // "translations" with its quotes
  function automatic logic [7:0] key1_char(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h22;
      4'd1:    return 8'h74;
      4'd2:    return 8'h72;
      4'd3:    return 8'h61;
      4'd4:    return 8'h6E;
      4'd5:    return 8'h73;
      4'd6:    return 8'h6C;
      4'd7:    return 8'h61;
      4'd8:    return 8'h74;
      4'd9:    return 8'h69;
      4'd10:   return 8'h6F;
      4'd11:   return 8'h6E;
      4'd12:   return 8'h73;
      4'd13:   return 8'h22;
      default: return 8'h00;
    endcase
  endfunction

  // "text" with its quotes
  function automatic logic [7:0] key2_char(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h22;
      4'd1:    return 8'h74;
      4'd2:    return 8'h65;
      4'd3:    return 8'h78;
      4'd4:    return 8'h74;
      4'd5:    return 8'h22;
      default: return 8'h00;
    endcase
  endfunction

  // valid flag and value of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  // simple escapes, anything else passes through
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    case (c)
      8'h62:   return 8'h08;
      8'h66:   return 8'h0C;
      8'h6E:   return 8'h0A;
      8'h72:   return 8'h0D;
      8'h74:   return 8'h09;
      default: return c;
    endcase
  endfunction

  // high surrogate as a code point
  function automatic logic [20:0] surr_cp(input logic [9:0] hs);
    return {5'd0, 6'b110110, hs};
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  match_q, match_d;
  logic [15:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;
  logic        emitted_q, emitted_d;
  cmd_t        cmd;
  logic [7:0]  c;
  logic [4:0]  hex;
  logic [15:0] acc_sh;
  logic [3:0]  match_nx;
  logic        do_str, do_esc, accept;

  assign c      = in_data_i.in_byte;
  assign hex    = hex_digit(c);
  assign acc_sh = {acc_q[11:0], hex[3:0]};
  assign accept = in_valid_i && !full_i;

  assign in_stall_o = full_i;
  assign push_o     = accept && (cmd.cp_valid || cmd.data_valid || cmd.stat_valid);
  assign cmd_o      = cmd;

  // next state and command for the current word
  always_comb begin
    phase_d   = phase_q;
    match_d   = match_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    hs_d      = hs_q;
    emitted_d = emitted_q;
    cmd       = '0;
    do_str    = 1'b0;
    do_esc    = 1'b0;
    match_nx  = '0;

    unique case (phase_q)
      PhKey1: begin
        if (match_q < Key1Len && key1_char(match_q) == c) begin
          match_nx = match_q + 4'd1;
        end else begin
          match_nx = (c == Quote) ? 4'd1 : 4'd0;
        end
        if (match_nx >= Key1Len) begin
          phase_d = PhKey2;
          match_d = 4'd1;
        end else begin
          match_d = match_nx;
        end
      end
      PhKey2: begin
        if (match_q < Key2Len && key2_char(match_q) == c) begin
          match_nx = match_q + 4'd1;
        end else begin
          match_nx = (c == Quote) ? 4'd1 : 4'd0;
        end
        if (match_nx >= Key2Len) begin
          phase_d = PhOpen;
          match_d = 4'd0;
        end else begin
          match_d = match_nx;
        end
      end
      PhOpen: begin
        if (c == Quote) phase_d = PhStr;
      end
      PhStr: begin
        do_str = 1'b1;
      end
      PhEsc: begin
        do_esc = 1'b1;
      end
      PhHex1: begin
        if (!hex[4]) begin
          phase_d = PhFail;
        end else begin
          acc_d = acc_sh;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            if (acc_sh[15:10] == 6'b110110) begin
              hs_d    = acc_sh[9:0];
              phase_d = PhPairB;
            end else begin
              cmd.cp_valid = 1'b1;
              cmd.cp       = {5'd0, acc_sh};
              phase_d      = PhStr;
            end
          end
        end
      end
      PhPairB: begin
        if (c == Backslash) begin
          phase_d = PhPairU;
        end else begin
          cmd.cp_valid = 1'b1;
          cmd.cp       = surr_cp(hs_q);
          do_str       = 1'b1;
        end
      end
      PhPairU: begin
        if (c == LetterU) begin
          phase_d = PhHex2;
          acc_d   = '0;
          cnt_d   = '0;
        end else begin
          cmd.cp_valid = 1'b1;
          cmd.cp       = surr_cp(hs_q);
          do_esc       = 1'b1;
        end
      end
      PhHex2: begin
        if (!hex[4]) begin
          phase_d = PhFail;
        end else begin
          acc_d = acc_sh;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            cmd.cp_valid = 1'b1;
            phase_d      = PhStr;
            if (acc_sh[15:10] == 6'b110111) begin
              cmd.cp = 21'h10000 + {1'b0, hs_q, acc_sh[9:0]};
            end else begin
              cmd.cp = surr_cp(hs_q);
            end
          end
        end
      end
      PhDone, PhFail: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = PhFail;
      end
    endcase

    // plain string byte
    if (do_str) begin
      if (c == Quote) begin
        phase_d = PhDone;
      end else if (c == Backslash) begin
        phase_d = PhEsc;
      end else begin
        phase_d        = PhStr;
        cmd.data_valid = 1'b1;
        cmd.data       = c;
      end
    end

    // byte after a backslash
    if (do_esc) begin
      if (c == LetterU) begin
        phase_d = PhHex1;
        acc_d   = '0;
        cnt_d   = '0;
      end else begin
        phase_d        = PhStr;
        cmd.data_valid = 1'b1;
        cmd.data       = esc_map(c);
      end
    end

    emitted_d = emitted_q || cmd.cp_valid || cmd.data_valid;

    // status at the last word of the response, then back to the start
    if (in_data_i.in_end) begin
      cmd.stat_valid = 1'b1;
      unique case (phase_d) inside
        PhKey1, PhKey2, PhOpen: begin
          cmd.stat_kind = KIND_NOKEY;
        end
        PhHex1, PhHex2, PhFail: begin
          cmd.stat_kind = KIND_BADHEX;
        end
        PhPairB, PhPairU: begin
          cmd.cp_valid  = 1'b1;
          cmd.cp        = surr_cp(hs_d);
          cmd.stat_kind = KIND_DONE;
        end
        default: begin
          cmd.stat_kind = emitted_d ? KIND_DONE : KIND_EMPTY;
        end
      endcase
      phase_d   = PhKey1;
      match_d   = '0;
      acc_d     = '0;
      cnt_d     = '0;
      hs_d      = '0;
      emitted_d = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhKey1;
      match_q   <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      hs_q      <= '0;
      emitted_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      match_q   <= match_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      hs_q      <= hs_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ----- rtl/jtfu_back.sv -----
// ----------------------------------------------------------------------------
// jtfu_back
// Turns a command into utf-8, data and status words, one per unstalled cycle.
// ----------------------------------------------------------------------------
module jtfu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  jtfu_pkg::cmd_t      q_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jtfu_pkg::out_word_t out_data_o
);
  import jtfu_pkg::*;

  logic [20:0] cp;
  logic [7:0]  cp_byte [4];
  logic [2:0]  cp_len, n_cp, total, idx_q;
  logic        last, load, out_valid_q;
  out_word_t   word, out_q;

  assign cp = q_cmd_i.cp;

  // utf-8 encoding of the code point
  always_comb begin
    cp_byte[0] = '0;
    cp_byte[1] = '0;
    cp_byte[2] = '0;
    cp_byte[3] = '0;
    if (cp <= 21'h7F) begin
      cp_len     = 3'd1;
      cp_byte[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      cp_len     = 3'd2;
      cp_byte[0] = {3'b110, cp[10:6]};
      cp_byte[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      cp_len     = 3'd3;
      cp_byte[0] = {4'b1110, cp[15:12]};
      cp_byte[1] = {2'b10, cp[11:6]};
      cp_byte[2] = {2'b10, cp[5:0]};
    end else begin
      cp_len     = 3'd4;
      cp_byte[0] = {5'b11110, cp[20:18]};
      cp_byte[1] = {2'b10, cp[17:12]};
      cp_byte[2] = {2'b10, cp[11:6]};
      cp_byte[3] = {2'b10, cp[5:0]};
    end
  end

  assign n_cp  = q_cmd_i.cp_valid ? cp_len : 3'd0;
  assign total = n_cp + {2'b0, q_cmd_i.data_valid} + {2'b0, q_cmd_i.stat_valid};
  assign last  = (idx_q == total - 3'd1);

  // pick the word at the current position
  always_comb begin
    word.out_last = last;
    if (idx_q < n_cp) begin
      word.out_byte = cp_byte[idx_q[1:0]];
      word.out_kind = KIND_DATA;
    end else if (q_cmd_i.data_valid && idx_q == n_cp) begin
      word.out_byte = q_cmd_i.data;
      word.out_kind = KIND_DATA;
    end else begin
      word.out_byte = '0;
      word.out_kind = q_cmd_i.stat_kind;
    end
  end

  assign load        = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // position within the command and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= last ? 3'd0 : idx_q + 3'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word;
    end
  end

endmodule

// ----- rtl/json_text_field_unescaper.sv -----
// ----------------------------------------------------------------------------
// json_text_field_unescaper
// Pulls the "text" value after the "translations" key out of a JSON
// response and emits it unescaped as utf-8.
// ----------------------------------------------------------------------------
// Input channel: one response byte per word, in_end set on the last byte.
// Output channel: one word per result, a utf-8 data byte or a status
// (done, key not found, bad hex escape, empty text); out_last marks the
// final word caused by an input byte, and the last byte of a response
// always gives one status word.
// With queue and output empty, the first word for an input byte passes
// through the command queue and the output register of the back end.
// Throughput is one input byte per cycle while the queue is not full and
// each byte gives at most one word; a byte can give up to 5 words, which
// leave one at a time through the back end's single output register.
// The command queue (QueueDepth entries) absorbs such bursts; input stall
// rises only when it is full.
// Reset clears the parser to the key search and empties queue and output.
// When the receiver stalls, the output word holds and the queue fills.
// ----------------------------------------------------------------------------
module json_text_field_unescaper #(
  parameter int unsigned QueueDepth = jtfu_pkg::DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jtfu_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jtfu_pkg::out_word_t out_data_o
);
  import jtfu_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic push, full, q_valid, pop;

  // parser front end
  jtfu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // command queue
  jtfu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  // utf-8 back end
  jtfu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/jtfu_checker.sv -----
// ----------------------------------------------------------------------------
// jtfu_checker
// Port-level checks of the unescaper output over time.
// ----------------------------------------------------------------------------
`include "json_text_field_unescaper_macros.svh"

module jtfu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input jtfu_pkg::out_word_t out_data_o
);
  import jtfu_pkg::*;

  // stalled output word holds
  `JTFU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "output word changed under stall")

  // a status word closes the results of its byte
  `JTFU_ASSERT(a_status_last, clk_i, rst_ni, out_valid_o && out_data_o.out_kind != KIND_DATA |-> out_data_o.out_last, "status word without last")

  // status words carry a zero byte
  `JTFU_ASSERT(a_status_zero, clk_i, rst_ni, out_valid_o && out_data_o.out_kind != KIND_DATA |-> out_data_o.out_byte == 8'h00, "status word with nonzero byte")

  // words of one byte follow without a gap
  `JTFU_ASSERT_NEXT(a_burst, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_data_o.out_last, out_valid_o, "gap inside the words of one byte")

  // input only stalls while a word waits at the output
  `JTFU_ASSERT(a_stall_busy, clk_i, rst_ni, in_stall_o |-> out_valid_o, "input stall while the output is idle")

endmodule

bind json_text_field_unescaper jtfu_checker u_jtfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
